// File: hdl/modtcp_pkg.sv
// shared types, constants and codes for the modbus tcp request checker
`default_nettype none
package modtcp_pkg;

    localparam int MAX_QUANTITY_DEF = 64;

    localparam int FIFO_DEPTH = 2;

    // byte positions of the captured header fields
    localparam logic [7:0] POS_TID_HI  = 8'd0;
    localparam logic [7:0] POS_TID_LO  = 8'd1;
    localparam logic [7:0] POS_UNIT    = 8'd6;
    localparam logic [7:0] POS_FUNC    = 8'd7;
    localparam logic [7:0] POS_ADDR_HI = 8'd8;
    localparam logic [7:0] POS_ADDR_LO = 8'd9;
    localparam logic [7:0] POS_QTY_HI  = 8'd10;
    localparam logic [7:0] POS_QTY_LO  = 8'd11;
    localparam logic [7:0] POS_LAST    = 8'd255;

    // function codes
    localparam logic [7:0] FC_RD_COILS    = 8'd1;
    localparam logic [7:0] FC_RD_DISCRETE = 8'd2;
    localparam logic [7:0] FC_RD_HOLDING  = 8'd3;
    localparam logic [7:0] FC_RD_INPUT    = 8'd4;
    localparam logic [7:0] FC_WR_COIL     = 8'd5;
    localparam logic [7:0] FC_WR_MULTI    = 8'd16;

    // frame and response sizes
    localparam logic [8:0] MIN_FRAME_LEN  = 9'd12;
    localparam logic [9:0] MULTI_HDR_LEN  = 10'd13;
    localparam logic [8:0] RESP_HDR_LEN   = 9'd9;
    localparam logic [8:0] WRITE_RESP_LEN = 9'd12;
    localparam logic [15:0] COIL_ON_WORD  = 16'hFF00;

    // register indexes
    localparam logic [0:0] REG_UNIT_ID    = 1'b0;
    localparam logic [0:0] REG_CHECK_UNIT = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_UNIT     = 3'd2,
        ST_BAD_FUNC = 3'd3,
        ST_QTY      = 3'd4,
        ST_BAD_LEN  = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] transaction_id;
        logic [7:0]  reply_unit;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] quantity;
        logic        coil_on;
        logic [7:0]  response_length;
        logic [7:0]  data_byte_count;
    } t_out_item;

    // one finished frame as handed from the front to the back
    typedef struct packed {
        logic [8:0]  flen;
        logic [15:0] trans_id;
        logic [7:0]  unit;
        logic [7:0]  func;
        logic [15:0] addr;
        logic [15:0] qty;
    } t_frame;

    typedef struct packed {
        logic [7:0] unit_id;
        logic       check_unit_id;
    } t_cfg;

endpackage
`default_nettype wire

// File: hdl/modtcp_front.sv
// byte counter and header capture, pushes one record per frame
`default_nettype none
module modtcp_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  modtcp_pkg::t_in_item i_in_item,
    output logic                 o_in_stall,
    input  wire                  i_q_full,
    output logic                 o_push,
    output modtcp_pkg::t_frame   o_frame
);

    logic [7:0]  r_pos;
    logic [15:0] r_tid;
    logic [7:0]  r_unit;
    logic [7:0]  r_func;
    logic [15:0] r_addr;
    logic [15:0] r_qty;

    logic [15:0] n_tid;
    logic [7:0]  n_unit;
    logic [7:0]  n_func;
    logic [15:0] n_addr;
    logic [15:0] n_qty;
    logic [7:0]  n_pos;
    logic [8:0]  flen;
    logic        accept;
    logic [7:0]  b;

    assign b          = i_in_item.frame_byte;
    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_tid  = r_tid;
        n_unit = r_unit;
        n_func = r_func;
        n_addr = r_addr;
        n_qty  = r_qty;
        case (r_pos)
            modtcp_pkg::POS_TID_HI:  n_tid[15:8]  = b;
            modtcp_pkg::POS_TID_LO:  n_tid[7:0]   = b;
            modtcp_pkg::POS_UNIT:    n_unit       = b;
            modtcp_pkg::POS_FUNC:    n_func       = b;
            modtcp_pkg::POS_ADDR_HI: n_addr[15:8] = b;
            modtcp_pkg::POS_ADDR_LO: n_addr[7:0]  = b;
            modtcp_pkg::POS_QTY_HI:  n_qty[15:8]  = b;
            modtcp_pkg::POS_QTY_LO:  n_qty[7:0]   = b;
            default: ;
        endcase
        // count saturates, length then reads as 256
        if (r_pos == modtcp_pkg::POS_LAST) begin
            n_pos = r_pos;
            flen  = 9'd256;
        end else begin
            n_pos = r_pos + 8'd1;
            flen  = {1'b0, n_pos};
        end
    end

    assign o_push         = accept && i_in_item.frame_end;
    assign o_frame.flen     = flen;
    assign o_frame.trans_id = n_tid;
    assign o_frame.unit     = n_unit;
    assign o_frame.func     = n_func;
    assign o_frame.addr     = n_addr;
    assign o_frame.qty      = n_qty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_tid  <= '0;
            r_unit <= '0;
            r_func <= '0;
            r_addr <= '0;
            r_qty  <= '0;
        end else if (accept) begin
            if (i_in_item.frame_end) begin
                r_pos  <= '0;
                r_tid  <= '0;
                r_unit <= '0;
                r_func <= '0;
                r_addr <= '0;
                r_qty  <= '0;
            end else begin
                r_pos  <= n_pos;
                r_tid  <= n_tid;
                r_unit <= n_unit;
                r_func <= n_func;
                r_addr <= n_addr;
                r_qty  <= n_qty;
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/modtcp_fifo.sv
// short queue of frame records between front and back
`default_nettype none
module modtcp_fifo (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  modtcp_pkg::t_frame i_data,
    output logic               o_full,
    input  wire                i_pop,
    output logic               o_valid,
    output modtcp_pkg::t_frame o_data
);

    localparam int AW = $clog2(modtcp_pkg::FIFO_DEPTH);
    localparam logic [AW:0] DEPTH_C = (AW + 1)'(modtcp_pkg::FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_C = AW'(modtcp_pkg::FIFO_DEPTH - 1);

    modtcp_pkg::t_frame r_mem [modtcp_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == DEPTH_C);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_C) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_C) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("frame record pushed into full queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_C)
        else $error("queue count out of range");
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |=> !(r_cnt > (AW + 1)'(1)))
        else $error("queue grew by more than one item");

endmodule
`default_nettype wire

// File: hdl/modtcp_back.sv
// request checks, response sizing and output register
`default_nettype none
module modtcp_back #(
    parameter int MAX_QUANTITY = modtcp_pkg::MAX_QUANTITY_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  modtcp_pkg::t_cfg      i_cfg,
    input  wire                   i_q_valid,
    input  modtcp_pkg::t_frame    i_q_data,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output modtcp_pkg::t_out_item o_out_item
);

    localparam logic [15:0] MAX_Q = 16'(MAX_QUANTITY);

    modtcp_pkg::t_status  status;
    modtcp_pkg::t_out_item n_out;
    modtcp_pkg::t_out_item r_out;
    logic       r_valid;
    logic [15:0] q;
    logic [8:0]  flen;
    logic [7:0]  q8;
    logic [7:0]  qm1;
    logic [9:0]  multi_len;
    logic [8:0]  rlen;
    logic [7:0]  count;
    logic        coil;

    assign q         = i_q_data.qty;
    assign flen      = i_q_data.flen;
    assign q8        = q[7:0];
    assign qm1       = q8 - 8'd1;
    assign multi_len = modtcp_pkg::MULTI_HDR_LEN + {1'b0, q8, 1'b0};

    always_comb begin
        status = modtcp_pkg::ST_OK;
        rlen   = '0;
        count  = '0;
        coil   = 1'b0;
        if (flen < modtcp_pkg::MIN_FRAME_LEN) begin
            status = modtcp_pkg::ST_SHORT;
        end else if (i_cfg.check_unit_id && (i_q_data.unit != i_cfg.unit_id)) begin
            status = modtcp_pkg::ST_UNIT;
        end else begin
            case (i_q_data.func)
                modtcp_pkg::FC_RD_COILS, modtcp_pkg::FC_RD_DISCRETE,
                modtcp_pkg::FC_RD_HOLDING, modtcp_pkg::FC_RD_INPUT,
                modtcp_pkg::FC_WR_MULTI: begin
                    // past this check q fits in 7 bits
                    if (q > MAX_Q) begin
                        status = modtcp_pkg::ST_QTY;
                    end else if (i_q_data.func == modtcp_pkg::FC_WR_MULTI) begin
                        if ({1'b0, flen} != multi_len) begin
                            status = modtcp_pkg::ST_BAD_LEN;
                        end else begin
                            rlen = modtcp_pkg::WRITE_RESP_LEN;
                        end
                    end else if (flen != modtcp_pkg::MIN_FRAME_LEN) begin
                        status = modtcp_pkg::ST_BAD_LEN;
                    end else if (i_q_data.func == modtcp_pkg::FC_RD_COILS ||
                                 i_q_data.func == modtcp_pkg::FC_RD_DISCRETE) begin
                        // one status bit per coil, zero quantity still takes a byte
                        count = (q8 == 8'd0) ? 8'd1 : ({3'b000, qm1[7:3]} + 8'd1);
                        rlen  = modtcp_pkg::RESP_HDR_LEN + {1'b0, count};
                    end else begin
                        count = {q8[6:0], 1'b0};
                        rlen  = modtcp_pkg::RESP_HDR_LEN + {1'b0, count};
                    end
                end
                modtcp_pkg::FC_WR_COIL: begin
                    if (flen != modtcp_pkg::MIN_FRAME_LEN) begin
                        status = modtcp_pkg::ST_BAD_LEN;
                    end else begin
                        rlen = modtcp_pkg::WRITE_RESP_LEN;
                        coil = (q == modtcp_pkg::COIL_ON_WORD);
                    end
                end
                default: status = modtcp_pkg::ST_BAD_FUNC;
            endcase
        end

        n_out.status          = status;
        n_out.transaction_id  = i_q_data.trans_id;
        n_out.reply_unit      = i_q_data.unit;
        n_out.function_code   = i_q_data.func;
        n_out.start_address   = i_q_data.addr;
        n_out.quantity        = q;
        n_out.coil_on         = coil;
        n_out.response_length = rlen[8] ? 8'hFF : rlen[7:0];
        n_out.data_byte_count = count;
    end

    assign o_pop       = i_q_valid && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.status != modtcp_pkg::ST_OK) |->
        (r_out.response_length == 8'd0 && r_out.data_byte_count == 8'd0 && !r_out.coil_on))
        else $error("rejected request carries response sizes");
    a_coil_func: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.coil_on) |-> (r_out.function_code == modtcp_pkg::FC_WR_COIL))
        else $error("coil_on set for a function other than write single coil");
    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.status == modtcp_pkg::ST_OK) |->
        (r_out.response_length >= 8'd9))
        else $error("accepted request with response shorter than header");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_out_stall) |-> !o_pop)
        else $error("held result overwritten");

endmodule
`default_nettype wire

// File: hdl/modbus_tcp_request_checker.sv
// Modbus TCP request checker: takes request bytes in order, one byte per item,
// with frame_end on the last byte of each frame. For every frame it gives one
// result item holding the check status, the decoded header and the size of the
// response a server would send. Items without frame_end give no result.
// Input channel: one byte per cycle sustained; o_in_stall rises only while the
// two-entry frame queue is full, i.e. when two finished frames wait behind a
// stalled output. Result path: the queue is written at the edge that takes the
// last byte, the output register on the pop; o_out_item then holds until taken.
// The back end takes one frame per cycle while the output is not stalled.
// Configuration: unit_id at paddr 0, check_unit_id at paddr 4, written over the
// apb port; pready is tied high. The user must write them only while no frame
// is in flight; the block does not enforce this. Reset (synchronous, active
// low) clears the byte counter, header capture, queue and output valid, and
// sets unit_id to 1 and check_unit_id to 1. A stalled result holds; the queue
// keeps bytes flowing until it fills.
`default_nettype none
module modbus_tcp_request_checker #(
    parameter int MAX_QUANTITY = modtcp_pkg::MAX_QUANTITY_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  modtcp_pkg::t_in_item  i_in_item,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output modtcp_pkg::t_out_item o_out_item,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [2:0]            paddr,
    input  wire  [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [7:0] r_unit_id;
    logic       r_check_unit;
    logic       cfg_wr;
    logic [0:0] reg_idx;

    modtcp_pkg::t_cfg   cfg;
    modtcp_pkg::t_frame push_frame;
    modtcp_pkg::t_frame head_frame;
    logic push;
    logic q_full;
    logic q_valid;
    logic pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_id    <= 8'd1;
            r_check_unit <= 1'b1;
        end else if (cfg_wr) begin
            case (reg_idx)
                modtcp_pkg::REG_UNIT_ID:    r_unit_id    <= pwdata[7:0];
                modtcp_pkg::REG_CHECK_UNIT: r_check_unit <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            modtcp_pkg::REG_UNIT_ID:    prdata = {24'd0, r_unit_id};
            modtcp_pkg::REG_CHECK_UNIT: prdata = {31'd0, r_check_unit};
            default:                    prdata = '0;
        endcase
    end

    assign cfg.unit_id       = r_unit_id;
    assign cfg.check_unit_id = r_check_unit;

    modtcp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_frame    (push_frame)
    );

    modtcp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_frame),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (head_frame)
    );

    modtcp_back #(
        .MAX_QUANTITY (MAX_QUANTITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_data    (head_frame),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// File: dv/tb_modbus_tcp_request_checker.sv
// testbench for the modbus tcp request checker: random and directed frames, scoreboard check
`timescale 1ns / 1ps
module tb_modbus_tcp_request_checker;

    localparam int QTY_MAX        = modtcp_pkg::MAX_QUANTITY_DEF;
    localparam int PHASE_BYTES    = 60;
    localparam int NUM_PHASES     = 5;
    localparam int WATCHDOG_LIMIT = 400;

    class reply_scoreboard;
        logic [7:0]  cfg_unit  = 8'd1;
        logic        cfg_check = 1'b1;
        logic [7:0]  pos;
        logic [15:0] tid;
        logic [7:0]  unit;
        logic [7:0]  func;
        logic [15:0] addr;
        logic [15:0] qty;
        modtcp_pkg::t_out_item expected_replies[$];
        int          errors;

        function new();
            clear_frame();
        endfunction

        function void clear_frame();
            pos  = '0;
            tid  = '0;
            unit = '0;
            func = '0;
            addr = '0;
            qty  = '0;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void take_request_byte(modtcp_pkg::t_in_item it);
            modtcp_pkg::t_out_item e;
            modtcp_pkg::t_status   st;
            int unsigned flen;
            int unsigned q;
            int unsigned cnt;
            int unsigned rlen;
            logic        coil;
            logic        sat;
            case (pos)
                modtcp_pkg::POS_TID_HI:  tid[15:8]  = it.frame_byte;
                modtcp_pkg::POS_TID_LO:  tid[7:0]   = it.frame_byte;
                modtcp_pkg::POS_UNIT:    unit       = it.frame_byte;
                modtcp_pkg::POS_FUNC:    func       = it.frame_byte;
                modtcp_pkg::POS_ADDR_HI: addr[15:8] = it.frame_byte;
                modtcp_pkg::POS_ADDR_LO: addr[7:0]  = it.frame_byte;
                modtcp_pkg::POS_QTY_HI:  qty[15:8]  = it.frame_byte;
                modtcp_pkg::POS_QTY_LO:  qty[7:0]   = it.frame_byte;
                default: ;
            endcase
            sat = (pos == modtcp_pkg::POS_LAST);
            if (!sat) pos = pos + 8'd1;
            if (!it.frame_end) return;

            // past the counter limit the length can never match
            flen = sat ? 256 : pos;
            q    = qty;
            cnt  = 0;
            rlen = 0;
            coil = 1'b0;
            st   = modtcp_pkg::ST_OK;
            if (flen < modtcp_pkg::MIN_FRAME_LEN) begin
                st = modtcp_pkg::ST_SHORT;
            end else if (cfg_check && unit != cfg_unit) begin
                st = modtcp_pkg::ST_UNIT;
            end else begin
                case (func)
                    modtcp_pkg::FC_RD_COILS, modtcp_pkg::FC_RD_DISCRETE,
                    modtcp_pkg::FC_RD_HOLDING, modtcp_pkg::FC_RD_INPUT,
                    modtcp_pkg::FC_WR_MULTI: begin
                        if (q > QTY_MAX) begin
                            st = modtcp_pkg::ST_QTY;
                        end else if (func == modtcp_pkg::FC_WR_MULTI) begin
                            if (flen != modtcp_pkg::MULTI_HDR_LEN + 2 * q)
                                st = modtcp_pkg::ST_BAD_LEN;
                            else rlen = modtcp_pkg::WRITE_RESP_LEN;
                        end else if (flen != modtcp_pkg::MIN_FRAME_LEN) begin
                            st = modtcp_pkg::ST_BAD_LEN;
                        end else if (func == modtcp_pkg::FC_RD_COILS ||
                                     func == modtcp_pkg::FC_RD_DISCRETE) begin
                            cnt  = (q == 0) ? 1 : (q - 1) / 8 + 1;
                            rlen = modtcp_pkg::RESP_HDR_LEN + cnt;
                        end else begin
                            cnt  = 2 * q;
                            rlen = modtcp_pkg::RESP_HDR_LEN + cnt;
                        end
                    end
                    modtcp_pkg::FC_WR_COIL: begin
                        if (flen != modtcp_pkg::MIN_FRAME_LEN) begin
                            st = modtcp_pkg::ST_BAD_LEN;
                        end else begin
                            rlen = modtcp_pkg::WRITE_RESP_LEN;
                            coil = (qty == modtcp_pkg::COIL_ON_WORD);
                        end
                    end
                    default: st = modtcp_pkg::ST_BAD_FUNC;
                endcase
            end
            if (st != modtcp_pkg::ST_OK) begin
                cnt  = 0;
                rlen = 0;
                coil = 1'b0;
            end
            if (rlen > 255) rlen = 255;
            if (cnt > 255) cnt = 255;

            e.status          = st;
            e.transaction_id  = tid;
            e.reply_unit      = unit;
            e.function_code   = func;
            e.start_address   = addr;
            e.quantity        = qty;
            e.coil_on         = coil;
            e.response_length = rlen[7:0];
            e.data_byte_count = cnt[7:0];
            expected_replies.push_back(e);
            clear_frame();
        endfunction

        function void check_reply(modtcp_pkg::t_out_item got);
            modtcp_pkg::t_out_item e;
            string     diff;
            if (expected_replies.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item %h", got);
                return;
            end
            e = expected_replies.pop_front();
            diff = "";
            if (got.status !== e.status) diff = {diff, " status"};
            if (got.transaction_id !== e.transaction_id) diff = {diff, " transaction_id"};
            if (got.reply_unit !== e.reply_unit) diff = {diff, " reply_unit"};
            if (got.function_code !== e.function_code) diff = {diff, " function_code"};
            if (got.start_address !== e.start_address) diff = {diff, " start_address"};
            if (got.quantity !== e.quantity) diff = {diff, " quantity"};
            if (got.coil_on !== e.coil_on) diff = {diff, " coil_on"};
            if (got.response_length !== e.response_length) diff = {diff, " response_length"};
            if (got.data_byte_count !== e.data_byte_count) diff = {diff, " data_byte_count"};
            if (diff != "") begin
                errors++;
                if (errors <= 10)
                    $display("result differs in%s: expected %h got %h", diff, e, got);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    modtcp_pkg::t_in_item  i_in_item = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    modtcp_pkg::t_out_item o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    reply_scoreboard sb;
    logic [7:0]      frame_buf[$];
    int              idle_odds = 20;
    bit              calm = 1'b0;
    int              bytes_sent = 0;
    int              stall_left = 0;
    int              idle_cycles = 0;

    modbus_tcp_request_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // result side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!calm && idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
            stall_left = $urandom_range(0, 5);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        bit moved;
        moved = 1'b0;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.take_request_byte(i_in_item);
            moved = 1'b1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_reply(o_out_item);
            moved = 1'b1;
        end
        if (moved || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        modtcp_pkg::t_in_item it;
        int       gap;
        if (!calm && idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.frame_byte = b;
        it.frame_end  = last;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // header bytes 2..5 (protocol and length words) are not checked, so they are random
    task automatic make_request(input logic [15:0] tid, input logic [7:0] unit,
                                input logic [7:0] fc, input logic [15:0] addr,
                                input logic [15:0] qty, input int len);
        frame_buf = {tid[15:8], tid[7:0], 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), unit, fc, addr[15:8], addr[7:0], qty[15:8], qty[7:0]};
        while (frame_buf.size() > len) void'(frame_buf.pop_back());
        while (frame_buf.size() < len) frame_buf.push_back(8'($urandom));
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == modtcp_pkg::REG_UNIT_ID) sb.cfg_unit = val[7:0];
        else sb.cfg_check = val[0];
        @(posedge i_clk);
    endtask

    task automatic random_request();
        logic [7:0]  fc;
        logic [7:0]  unit;
        logic [15:0] qty;
        int          pick;
        int          good;
        int          len;
        if ($urandom_range(0, 99) < 85) begin
            case ($urandom_range(0, 5))
                0: fc = modtcp_pkg::FC_RD_COILS;
                1: fc = modtcp_pkg::FC_RD_DISCRETE;
                2: fc = modtcp_pkg::FC_RD_HOLDING;
                3: fc = modtcp_pkg::FC_RD_INPUT;
                4: fc = modtcp_pkg::FC_WR_COIL;
                default: fc = modtcp_pkg::FC_WR_MULTI;
            endcase
        end else begin
            fc = 8'($urandom);
        end
        unit = ($urandom_range(0, 9) < 8) ? sb.cfg_unit : 8'($urandom);
        if (fc == modtcp_pkg::FC_WR_COIL) begin
            case ($urandom_range(0, 2))
                0: qty = modtcp_pkg::COIL_ON_WORD;
                1: qty = 16'h0000;
                default: qty = 16'($urandom);
            endcase
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 75) qty = 16'($urandom_range(0, QTY_MAX));
            else if (pick < 88) qty = 16'($urandom_range(QTY_MAX + 1, QTY_MAX + 8));
            else qty = 16'($urandom);
        end
        good = (fc == modtcp_pkg::FC_WR_MULTI && qty <= QTY_MAX) ?
               modtcp_pkg::MULTI_HDR_LEN + 2 * qty : modtcp_pkg::MIN_FRAME_LEN;
        pick = $urandom_range(0, 99);
        if (pick < 78) len = good;
        else if (pick < 88) len = $urandom_range(1, 11);
        else if (pick < 99) len = good + $urandom_range(0, 4) - 2;
        else len = $urandom_range(256, 262);
        make_request(16'($urandom), unit, fc, 16'($urandom), qty, len);
        send_frame();
    endtask

    initial begin
        int phase_start;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames at the reset configuration
        make_request(16'h0000, 8'd1, modtcp_pkg::FC_RD_HOLDING, 16'h0000, 16'd0, 12);
        send_frame();
        make_request(16'hFFFF, 8'd1, modtcp_pkg::FC_RD_COILS, 16'h0000, 16'd0, 12);
        send_frame();
        make_request(16'h1234, 8'd1, modtcp_pkg::FC_RD_COILS, 16'hFFFF, 16'(QTY_MAX), 12);
        send_frame();
        make_request(16'h0001, 8'd1, modtcp_pkg::FC_RD_DISCRETE, 16'h8000, 16'd9, 12);
        send_frame();
        make_request(16'hA5A5, 8'd1, modtcp_pkg::FC_RD_INPUT, 16'h00FF, 16'(QTY_MAX), 12);
        send_frame();
        make_request(16'h5A5A, 8'd1, modtcp_pkg::FC_RD_HOLDING, 16'h0001,
                     16'(QTY_MAX + 1), 12);
        send_frame();
        make_request(16'h0F0F, 8'd1, modtcp_pkg::FC_RD_HOLDING, 16'h0002, 16'hFFFF, 12);
        send_frame();
        make_request(16'h00FF, 8'd1, modtcp_pkg::FC_WR_COIL, 16'h0010,
                     modtcp_pkg::COIL_ON_WORD, 12);
        send_frame();
        make_request(16'hFF00, 8'd1, modtcp_pkg::FC_WR_COIL, 16'h0011, 16'h0000, 12);
        send_frame();
        // coil value that is neither on nor off is still accepted
        make_request(16'h7777, 8'd1, modtcp_pkg::FC_WR_COIL, 16'h0012, 16'h1234, 12);
        send_frame();
        make_request(16'h2222, 8'd1, modtcp_pkg::FC_WR_COIL, 16'h0013,
                     modtcp_pkg::COIL_ON_WORD, 13);
        send_frame();
        make_request(16'h3333, 8'd1, modtcp_pkg::FC_WR_MULTI, 16'h0100, 16'd2, 17);
        send_frame();
        make_request(16'h4444, 8'd1, modtcp_pkg::FC_WR_MULTI, 16'h0100, 16'd2, 16);
        send_frame();
        make_request(16'h5555, 8'd1, modtcp_pkg::FC_WR_MULTI, 16'h0000, 16'd0, 13);
        send_frame();
        make_request(16'h6666, 8'd1, 8'd0, 16'h0000, 16'd1, 12);
        send_frame();
        make_request(16'h6667, 8'd1, 8'd255, 16'h0000, 16'd1, 12);
        send_frame();
        make_request(16'h6668, 8'd1, 8'd6, 16'h0000, 16'd1, 12);
        send_frame();
        make_request(16'h8888, 8'd2, modtcp_pkg::FC_RD_HOLDING, 16'h0000, 16'd1, 12);
        send_frame();
        // short frames leave the missing header fields at zero
        make_request(16'h9999, 8'd1, modtcp_pkg::FC_RD_HOLDING, 16'h0000, 16'd1, 1);
        send_frame();
        make_request(16'h9998, 8'd1, modtcp_pkg::FC_RD_HOLDING, 16'h0000, 16'd1, 7);
        send_frame();
        make_request(16'h9997, 8'd1, modtcp_pkg::FC_RD_HOLDING, 16'h1111, 16'd1, 11);
        send_frame();
        make_request(16'hAAAA, 8'd1, modtcp_pkg::FC_RD_HOLDING, 16'h0000, 16'd1, 13);
        send_frame();
        // long frames run the byte counter up to its limit and into saturation
        make_request(16'hBBBB, 8'd1, modtcp_pkg::FC_RD_HOLDING, 16'h0000, 16'd1, 255);
        send_frame();
        make_request(16'hCCCC, 8'd1, modtcp_pkg::FC_RD_HOLDING, 16'h0000, 16'd1, 256);
        send_frame();
        make_request(16'hDDDD, 8'd1, modtcp_pkg::FC_WR_COIL, 16'h0000,
                     modtcp_pkg::COIL_ON_WORD, 300);
        send_frame();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            case (phase)
                0: idle_odds = 20;
                1: begin
                    write_reg(modtcp_pkg::REG_UNIT_ID, 32'd0);
                    write_reg(modtcp_pkg::REG_CHECK_UNIT, 32'd1);
                    idle_odds = 0;
                end
                2: begin
                    write_reg(modtcp_pkg::REG_UNIT_ID, 32'd255);
                    write_reg(modtcp_pkg::REG_CHECK_UNIT, 32'd0);
                    idle_odds = 40;
                end
                3: begin
                    write_reg(modtcp_pkg::REG_UNIT_ID, $urandom_range(0, 255));
                    write_reg(modtcp_pkg::REG_CHECK_UNIT, 32'd1);
                    idle_odds = 15;
                end
                default: begin
                    write_reg(modtcp_pkg::REG_UNIT_ID, $urandom_range(0, 255));
                    write_reg(modtcp_pkg::REG_CHECK_UNIT, 32'd0);
                    idle_odds = 25;
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                // the tail of the run goes at full rate on both sides
                calm = (phase == NUM_PHASES - 1) && (bytes_sent - phase_start > PHASE_BYTES / 3);
                random_request();
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
